[sv/bcpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg_pkg
// Shared types, constants and fixed-point helpers for the Bezier point
// generator.
// ----------------------------------------------------------------------------
package bcpg_pkg;

  // curvature kinds carried with each vertex
  localparam logic [2:0] KIND_PREV       = 3'd0;
  localparam logic [2:0] KIND_NEXT       = 3'd1;
  localparam logic [2:0] KIND_BOTH       = 3'd2;
  localparam logic [2:0] KIND_CONST_NEXT = 3'd3;
  localparam logic [2:0] KIND_DONT_CARE  = 3'd4;

  localparam logic [15:0] RATIO_RESET = 16'd19661;

  // divider: signed dividend, magnitude bits and full width
  localparam int DIV_MAG_W = 49;
  localparam int DIV_W     = DIV_MAG_W + 1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [2:0]         kind;
    logic               last;
  } vtx_t;

  // clamp to the signed cb-bit range, then to 32 bits
  function automatic logic signed [31:0] sat_coord(input logic signed [39:0] v,
                                                   input int cb);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    int                 eb;
    eb = (cb < 32) ? cb : 32;
    hi = (40'sd1 <<< (eb - 1)) - 40'sd1;
    lo = -hi - 40'sd1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  // Q34.32 product back to Q34.16, truncated toward zero
  function automatic logic signed [49:0] mulq(input logic signed [65:0] p);
    logic signed [65:0] adj;
    adj = p + ((p < 66'sd0) ? 66'sd65535 : 66'sd0);
    return adj[65:16];
  endfunction

endpackage

[sv/bcpg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg channel interfaces
// Vertex input, point output and ratio write channels, valid/ready.
// ----------------------------------------------------------------------------
interface bcpg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic [2:0]         vertex_kind;
  logic               route_last;
  modport source (output valid, vertex_x, vertex_y, vertex_kind, route_last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_kind, route_last, output ready);
endinterface

interface bcpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [15:0]        segment_number;
  logic               segment_end;
  logic               run_end;
  modport source (output valid, point_x, point_y, segment_number, segment_end, run_end,
                  input ready);
  modport sink   (input valid, point_x, point_y, segment_number, segment_end, run_end,
                  output ready);
endinterface

interface bcpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] smooth_ratio;
  modport source (output valid, smooth_ratio, input ready);
  modport sink   (input valid, smooth_ratio, output ready);
endinterface

[sv/bezier_control_point_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_control_point_generator
// Streams route vertices in and Bezier point lists (start, control points,
// end) for each segment out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_vtx   | in  | valid/ready   | vertex_x, vertex_y, vertex_kind, route_last
//  out_pt   | out | valid/ready   | point_x, point_y, segment_number,
//           |     |               | segment_end, run_end
//  cfg_wr   | in  | valid/ready   | smooth_ratio (always ready)
//
// One vertex at a time. A vertex costs a square root, two divisions (none for
// a zero length) and the sequencing; consider-both adds one root and two more
// divisions; each emitted point adds its own transfer. The iterative root and
// divider units set that cost.
// A two-entry queue takes vertices while the back end works; a held result
// waits in the output register without stopping the queue.
// Reset (synchronous, rst_n low) clears the route and loads ratio 19661.
module bezier_control_point_generator #(
  parameter int COORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bcpg_in_if.sink    in_vtx,
  bcpg_out_if.source out_pt,
  bcpg_cfg_if.sink   cfg_wr
);

  logic [15:0]    ratio_r;
  bcpg_pkg::vtx_t head;
  logic           head_valid;
  logic           pop;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= bcpg_pkg::RATIO_RESET;
    end else if (cfg_wr.valid) begin
      ratio_r <= cfg_wr.smooth_ratio;
    end
  end

  bcpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vtx     (in_vtx),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  bcpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ratio      (ratio_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_pt     (out_pt)
  );

endmodule

[sv/bcpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg_front
// Takes vertices, clamps them to the coordinate range and queues them
// (two entries) for the back end.
// ----------------------------------------------------------------------------
module bcpg_front #(
  parameter int COORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  bcpg_in_if.sink         in_vtx,
  output bcpg_pkg::vtx_t  head,
  output logic            head_valid,
  input  logic            pop
);

  bcpg_pkg::vtx_t q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  bcpg_pkg::vtx_t entry;

  assign in_vtx.ready = (cnt_r != 2'd2);
  assign push         = in_vtx.valid && in_vtx.ready;
  assign head         = q_r[rd_ptr_r];
  assign head_valid   = (cnt_r != 2'd0);

  always_comb begin
    entry.x    = bcpg_pkg::sat_coord(40'(in_vtx.vertex_x), COORD_BITS);
    entry.y    = bcpg_pkg::sat_coord(40'(in_vtx.vertex_y), COORD_BITS);
    entry.kind = in_vtx.vertex_kind;
    entry.last = in_vtx.route_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= entry;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

[sv/bcpg_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg_isqrt
// Iterative 64-bit integer square root, rounded down, one result bit per
// cycle.
// ----------------------------------------------------------------------------
module bcpg_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [4:0]  k_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] bit_c;
  logic [63:0] trial;

  assign bit_c = 64'd1 << {k_r, 1'b0};
  assign trial = res_r + bit_c;
  assign done  = done_r;
  assign root  = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= rad;
        res_r  <= 64'd0;
        k_r    <= 5'd31;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_c;
        end else begin
          res_r <= res_r >> 1;
        end
        if (k_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r - 5'd1;
        end
      end
    end
  end

endmodule

[sv/bcpg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg_div
// Signed by unsigned restoring divider, quotient truncated toward zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcpg_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [bcpg_pkg::DIV_W-1:0] num,
  input  logic [31:0]                       den,
  output logic                              done,
  output logic signed [bcpg_pkg::DIV_W-1:0] quo
);

  localparam int MW = bcpg_pkg::DIV_MAG_W;

  logic [MW-1:0]                q_r;
  logic [31:0]                  rem_r;
  logic [31:0]                  den_r;
  logic [5:0]                   cnt_r;
  logic                         neg_r;
  logic                         busy_r;
  logic                         done_r;
  logic [32:0]                  sh;
  logic                         ge;
  logic [32:0]                  diff;
  logic signed [bcpg_pkg::DIV_W-1:0] mag_in;

  assign sh     = {rem_r, q_r[MW-1]};
  assign ge     = (sh >= {1'b0, den_r});
  assign diff   = sh - {1'b0, den_r};
  assign mag_in = (num < 0) ? -num : num;
  assign done   = done_r;
  assign quo    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= mag_in[MW-1:0];
        rem_r  <= 32'd0;
        den_r  <= den;
        neg_r  <= (num < 0);
        cnt_r  <= 6'(MW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[31:0] : sh[31:0];
        q_r   <= {q_r[MW-2:0], ge};
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

endmodule

[sv/bcpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg_back
// Per-vertex sequencer: segment vector, length, unit direction, control
// points by vertex kind, then streams out the finished point lists.
// ----------------------------------------------------------------------------
module bcpg_back #(
  parameter int COORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    ratio,
  input  bcpg_pkg::vtx_t head,
  input  logic           head_valid,
  output logic           pop,
  bcpg_out_if.source     out_pt
);

  typedef enum logic [4:0] {
    S_IDLE, S_SEG, S_M1, S_M2, S_SQ, S_SQW, S_DVX, S_DVY,
    S_LX, S_LY, S_LW, S_CTL, S_T, S_TW, S_PX, S_PY, S_QX, S_QY, S_QW,
    S_MX, S_K1, S_K2, S_K3, S_K3W, S_K4, S_K5, S_K6, S_K7, S_K8,
    S_E1, S_EMIT, S_FIN
  } state_t;

  typedef enum logic [1:0] {SLOT_P0, SLOT_P1, SLOT_CTRL, SLOT_END} slot_t;

  state_t             state_r;
  bcpg_pkg::vtx_t     it_r;
  logic [1:0]         vseen_r;
  logic signed [31:0] held_x_r, held_y_r;
  logic [2:0]         held_kind_r;
  logic signed [31:0] psx_r, psy_r;
  logic signed [17:0] pdx_r, pdy_r;
  logic [31:0]        plen_r;
  logic signed [31:0] pend_x_r [2];
  logic signed [31:0] pend_y_r [2];
  logic [1:0]         cnt_r;
  logic [15:0]        seg_r;
  logic signed [31:0] dx_r, dy_r;
  logic [31:0]        len_r;
  logic signed [17:0] ux_r, uy_r;
  logic signed [65:0] acc_r;
  logic signed [65:0] prod_r;
  logic signed [33:0] lx_r, ly_r;
  logic signed [32:0] t_r;
  logic signed [33:0] offp_x_r, offp_y_r, offq_x_r, offq_y_r;
  logic signed [17:0] mx_r, my_r;
  logic [16:0]        ml_r;
  logic               has_q_r;
  logic signed [31:0] ctrl_x_r, ctrl_y_r, end_x_r, end_y_r;
  logic               has_c_r;
  logic               final_r;
  slot_t              idx_r;
  slot_t              idx_nxt;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [15:0]        out_seg_r;
  logic               out_send_r, out_run_r;

  logic signed [32:0] mul_a, mul_b;
  logic               is_prev;
  logic signed [32:0] r33;
  logic signed [49:0] mq;
  logic               sq_start, sq_done;
  logic [63:0]        sq_rad;
  logic [31:0]        sq_root;
  logic               dv_start, dv_done;
  logic signed [49:0] dv_num, dv_quo;
  logic [31:0]        dv_den;
  logic signed [18:0] sum_x, sum_y;
  logic signed [17:0] mx_c, my_c;
  logic               out_free;
  logic signed [31:0] sel_x, sel_y;

  assign is_prev  = (held_kind_r == bcpg_pkg::KIND_PREV);
  assign r33      = $signed({17'd0, ratio});
  assign mq       = bcpg_pkg::mulq(prod_r);
  assign out_free = !out_valid_r || out_pt.ready;
  assign pop      = (state_r == S_IDLE) && head_valid;

  // halved sum of the two unit directions, toward zero
  assign sum_x = 19'(pdx_r) + 19'(ux_r);
  assign sum_y = 19'(pdy_r) + 19'(uy_r);
  assign mx_c  = 18'((sum_x + ((sum_x < 0) ? 19'sd1 : 19'sd0)) >>> 1);
  assign my_c  = 18'((sum_y + ((sum_y < 0) ? 19'sd1 : 19'sd0)) >>> 1);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1: begin mul_a = 33'(dx_r); mul_b = 33'(dx_r); end
      S_M2: begin mul_a = 33'(dy_r); mul_b = 33'(dy_r); end
      S_LX: begin mul_a = r33; mul_b = 33'(dx_r); end
      S_LY: begin mul_a = r33; mul_b = 33'(dy_r); end
      S_T: begin
        mul_a = r33;
        mul_b = is_prev ? $signed({1'b0, len_r}) : $signed({1'b0, plen_r});
      end
      S_PX: begin
        mul_a = is_prev ? r33 : t_r;
        mul_b = is_prev ? 33'(psx_r) : 33'(ux_r);
      end
      S_PY: begin
        mul_a = is_prev ? r33 : t_r;
        mul_b = is_prev ? 33'(psy_r) : 33'(uy_r);
      end
      S_QX: begin
        mul_a = is_prev ? t_r : r33;
        mul_b = is_prev ? 33'(pdx_r) : 33'(dx_r);
      end
      S_QY: begin
        mul_a = is_prev ? t_r : r33;
        mul_b = is_prev ? 33'(pdy_r) : 33'(dy_r);
      end
      S_K1: begin mul_a = 33'(mx_r); mul_b = 33'(mx_r); end
      S_K2: begin mul_a = 33'(my_r); mul_b = 33'(my_r); end
      S_K4: begin mul_a = t_r; mul_b = 33'(mx_r); end
      S_K5: begin mul_a = t_r; mul_b = 33'(my_r); end
      default: ;
    endcase
  end

  // square root and divider requests
  always_comb begin
    sq_start = (state_r == S_SQ) || (state_r == S_K3);
    sq_rad   = acc_r[63:0] + prod_r[63:0];
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    case (state_r)
      S_SQW: begin
        dv_start = sq_done && (sq_root != 32'd0);
        dv_num   = 50'(dx_r) <<< 16;
        dv_den   = sq_root;
      end
      S_DVX: begin
        dv_start = dv_done;
        dv_num   = 50'(dy_r) <<< 16;
        dv_den   = len_r;
      end
      S_K5: begin
        dv_start = 1'b1;
        dv_num   = prod_r[49:0];
        dv_den   = {15'd0, ml_r};
      end
      S_K7: begin
        dv_start = dv_done;
        dv_num   = acc_r[49:0];
        dv_den   = {15'd0, ml_r};
      end
      default: ;
    endcase
  end

  // next slot of the list, skipping the ones that are absent
  always_comb begin
    case (idx_r)
      SLOT_P0: idx_nxt = (cnt_r == 2'd2) ? SLOT_P1 : (has_c_r ? SLOT_CTRL : SLOT_END);
      SLOT_P1: idx_nxt = has_c_r ? SLOT_CTRL : SLOT_END;
      default: idx_nxt = SLOT_END;
    endcase
  end

  always_comb begin
    case (idx_r)
      SLOT_P0:   begin sel_x = pend_x_r[0]; sel_y = pend_y_r[0]; end
      SLOT_P1:   begin sel_x = pend_x_r[1]; sel_y = pend_y_r[1]; end
      SLOT_CTRL: begin sel_x = ctrl_x_r;    sel_y = ctrl_y_r;    end
      default:   begin sel_x = end_x_r;     sel_y = end_y_r;     end
    endcase
  end

  bcpg_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  bcpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign out_pt.valid          = out_valid_r;
  assign out_pt.point_x        = out_x_r;
  assign out_pt.point_y        = out_y_r;
  assign out_pt.segment_number = out_seg_r;
  assign out_pt.segment_end    = out_send_r;
  assign out_pt.run_end        = out_run_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vseen_r     <= 2'd0;
      cnt_r       <= 2'd0;
      seg_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      // S_EMIT reloads the output register itself
      if (out_pt.ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            it_r <= head;
            if (vseen_r == 2'd0) begin
              held_x_r    <= head.x;
              held_y_r    <= head.y;
              held_kind_r <= head.kind;
              vseen_r     <= head.last ? 2'd0 : 2'd1;
            end else begin
              state_r <= S_SEG;
            end
          end
        end
        S_SEG: begin
          dx_r    <= bcpg_pkg::sat_coord(40'(it_r.x) - 40'(held_x_r), 32);
          dy_r    <= bcpg_pkg::sat_coord(40'(it_r.y) - 40'(held_y_r), 32);
          state_r <= S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          acc_r   <= prod_r;
          state_r <= S_SQ;
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            len_r <= sq_root;
            if (sq_root == 32'd0) begin
              ux_r    <= '0;
              uy_r    <= '0;
              state_r <= S_LX;
            end else begin
              state_r <= S_DVX;
            end
          end
        end
        S_DVX: begin
          if (dv_done) begin
            ux_r    <= dv_quo[17:0];
            state_r <= S_DVY;
          end
        end
        S_DVY: begin
          if (dv_done) begin
            uy_r    <= dv_quo[17:0];
            state_r <= S_LX;
          end
        end
        S_LX: state_r <= S_LY;
        S_LY: begin
          lx_r    <= mq[33:0];
          state_r <= S_LW;
        end
        S_LW: begin
          ly_r    <= mq[33:0];
          state_r <= S_CTL;
        end
        S_CTL: begin
          if (vseen_r == 2'd1) begin
            // first segment: only the start vertex's own kind matters
            pend_x_r[0] <= held_x_r;
            pend_y_r[0] <= held_y_r;
            pend_x_r[1] <= bcpg_pkg::sat_coord(40'(held_x_r) + 40'(lx_r), COORD_BITS);
            pend_y_r[1] <= bcpg_pkg::sat_coord(40'(held_y_r) + 40'(ly_r), COORD_BITS);
            cnt_r       <= (held_kind_r == bcpg_pkg::KIND_NEXT) ? 2'd2 : 2'd1;
            psx_r       <= dx_r;
            psy_r       <= dy_r;
            pdx_r       <= ux_r;
            pdy_r       <= uy_r;
            plen_r      <= len_r;
            state_r     <= S_FIN;
          end else if (held_kind_r == bcpg_pkg::KIND_PREV ||
                       held_kind_r == bcpg_pkg::KIND_NEXT) begin
            state_r <= S_T;
          end else if (held_kind_r == bcpg_pkg::KIND_BOTH) begin
            state_r <= S_MX;
          end else begin
            has_q_r <= 1'b0;
            state_r <= S_E1;
          end
        end
        S_T: state_r <= S_TW;
        S_TW: begin
          t_r     <= mq[32:0];
          state_r <= (held_kind_r == bcpg_pkg::KIND_BOTH) ? S_K4 : S_PX;
        end
        S_PX: state_r <= S_PY;
        S_PY: begin
          offp_x_r <= mq[33:0];
          state_r  <= S_QX;
        end
        S_QX: begin
          offp_y_r <= mq[33:0];
          state_r  <= S_QY;
        end
        S_QY: begin
          offq_x_r <= mq[33:0];
          state_r  <= S_QW;
        end
        S_QW: begin
          offq_y_r <= mq[33:0];
          has_q_r  <= 1'b1;
          state_r  <= S_E1;
        end
        S_MX: begin
          mx_r <= mx_c;
          my_r <= my_c;
          // opposite directions cancel: no control point
          if (mx_c == 18'sd0 && my_c == 18'sd0) begin
            has_q_r <= 1'b0;
            state_r <= S_E1;
          end else begin
            state_r <= S_K1;
          end
        end
        S_K1: state_r <= S_K2;
        S_K2: begin
          acc_r   <= prod_r;
          state_r <= S_K3;
        end
        S_K3: state_r <= S_K3W;
        S_K3W: begin
          if (sq_done) begin
            ml_r    <= (sq_root == 32'd0) ? 17'd1 : sq_root[16:0];
            state_r <= S_T;
          end
        end
        S_K4: state_r <= S_K5;
        S_K5: state_r <= S_K6;
        S_K6: begin
          acc_r   <= prod_r;
          state_r <= S_K7;
        end
        S_K7: begin
          if (dv_done) begin
            offp_x_r <= dv_quo[33:0];
            offq_x_r <= dv_quo[33:0];
            state_r  <= S_K8;
          end
        end
        S_K8: begin
          if (dv_done) begin
            offp_y_r <= dv_quo[33:0];
            offq_y_r <= dv_quo[33:0];
            has_q_r  <= 1'b1;
            state_r  <= S_E1;
          end
        end
        S_E1: begin
          ctrl_x_r <= bcpg_pkg::sat_coord(40'(held_x_r) - 40'(offp_x_r), COORD_BITS);
          ctrl_y_r <= bcpg_pkg::sat_coord(40'(held_y_r) - 40'(offp_y_r), COORD_BITS);
          has_c_r  <= has_q_r;
          end_x_r  <= held_x_r;
          end_y_r  <= held_y_r;
          final_r  <= 1'b0;
          idx_r    <= SLOT_P0;
          state_r  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= sel_x;
            out_y_r     <= sel_y;
            out_seg_r   <= seg_r;
            out_send_r  <= (idx_r == SLOT_END);
            out_run_r   <= (idx_r == SLOT_END) && (final_r || !it_r.last);
            if (idx_r == SLOT_END) begin
              if (final_r) begin
                vseen_r <= 2'd0;
                cnt_r   <= 2'd0;
                seg_r   <= 16'd0;
                state_r <= S_IDLE;
              end else begin
                seg_r       <= seg_r + 16'd1;
                pend_x_r[0] <= held_x_r;
                pend_y_r[0] <= held_y_r;
                pend_x_r[1] <= bcpg_pkg::sat_coord(40'(held_x_r) + 40'(offq_x_r),
                                                   COORD_BITS);
                pend_y_r[1] <= bcpg_pkg::sat_coord(40'(held_y_r) + 40'(offq_y_r),
                                                   COORD_BITS);
                cnt_r       <= has_q_r ? 2'd2 : 2'd1;
                psx_r       <= dx_r;
                psy_r       <= dy_r;
                pdx_r       <= ux_r;
                pdy_r       <= uy_r;
                plen_r      <= len_r;
                state_r     <= S_FIN;
              end
            end else begin
              idx_r <= idx_nxt;
            end
          end
        end
        S_FIN: begin
          held_x_r    <= it_r.x;
          held_y_r    <= it_r.y;
          held_kind_r <= it_r.kind;
          vseen_r     <= 2'd2;
          if (it_r.last) begin
            ctrl_x_r <= bcpg_pkg::sat_coord(40'(it_r.x) - 40'(lx_r), COORD_BITS);
            ctrl_y_r <= bcpg_pkg::sat_coord(40'(it_r.y) - 40'(ly_r), COORD_BITS);
            has_c_r  <= (it_r.kind == bcpg_pkg::KIND_PREV);
            end_x_r  <= it_r.x;
            end_y_r  <= it_r.y;
            final_r  <= 1'b1;
            idx_r    <= SLOT_P0;
            state_r  <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/bcpg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpg_checker
// Port-level checks on the point output stream.
// ----------------------------------------------------------------------------
module bcpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [15:0] out_seg,
  input logic        out_send,
  input logic        out_run
);

  logic        open_r;
  logic [15:0] seg_r;

  // track whether the last transfer left a segment list open
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      open_r <= !out_send;
      seg_r  <= out_seg;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_seg) && $stable(out_send) && $stable(out_run))
    else $error("output changed while stalled");

  a_run_closes_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run |-> out_send)
    else $error("run end without segment end");

  a_seg_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && open_r |-> out_seg == seg_r)
    else $error("segment number changed inside a list");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bezier_control_point_generator bcpg_checker u_bcpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_pt.valid),
  .out_ready (out_pt.ready),
  .out_x     (out_pt.point_x),
  .out_y     (out_pt.point_y),
  .out_seg   (out_pt.segment_number),
  .out_send  (out_pt.segment_end),
  .out_run   (out_pt.run_end)
);
